// ===== src/bwm_pkg.sv =====
// ----------------------------------------------------------------------------
// bwm_pkg - shared types and constants of the breakpoint/watchpoint matcher
// Table sizes, address width, command, point type and stop signal codes,
// and the request/response structs passed between the top level and core.
// ----------------------------------------------------------------------------
package bwm_pkg;

  localparam int BREAK_ENTRIES = 16;
  localparam int WATCH_ENTRIES = 16;
  localparam int ADDR_WIDTH    = 32;

  localparam int BCNT_W = $clog2(BREAK_ENTRIES + 1);
  localparam int WCNT_W = $clog2(WATCH_ENTRIES + 1);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CHECK  = 2'd2
  } cmd_t;

  localparam logic [2:0] TYPE_SWBREAK = 3'd0;
  localparam logic [2:0] TYPE_HWBREAK = 3'd1;
  localparam logic [2:0] TYPE_WATCH   = 3'd2;
  localparam logic [2:0] TYPE_RWATCH  = 3'd3;
  localparam logic [2:0] TYPE_AWATCH  = 3'd4;

  localparam logic [1:0] MODE_WATCH  = 2'd0;
  localparam logic [1:0] MODE_RWATCH = 2'd1;
  localparam logic [1:0] MODE_AWATCH = 2'd2;

  localparam logic [1:0] SIG_NONE = 2'd0;
  localparam logic [1:0] SIGILL   = 2'd1;
  localparam logic [1:0] SIGTRAP  = 2'd2;

  typedef struct packed {
    cmd_t        command;
    logic [2:0]  point_type;
    logic [31:0] point_address;
    logic [3:0]  point_kind;
    logic [31:0] fetch_address;
    logic        fetch_illegal;
    logic [31:0] data_address;
    logic        data_read;
    logic        data_write;
  } req_t;

  typedef struct packed {
    logic [3:0] reason_kind;
    logic [2:0] reason_type;
    logic [1:0] stop_signal;
    logic       stop_hit;
    logic       table_full;
    logic [4:0] entry_count;
  } rsp_t;

endpackage

// ===== src/bwm_core.sv =====
// ----------------------------------------------------------------------------
// bwm_core - breakpoint and watchpoint tables with their match logic
// Holds both address-keyed tables, applies insert/remove when a request
// is executed and forms the response combinationally for the same request.
// ----------------------------------------------------------------------------
module bwm_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  bwm_pkg::req_t req,
  output bwm_pkg::rsp_t rsp
);
  import bwm_pkg::*;

  // table storage; payload is only read behind a valid bit
  logic [BREAK_ENTRIES-1:0] brk_valid_r;
  logic [BREAK_ENTRIES-1:0] brk_hw_r;
  logic [ADDR_WIDTH-1:0]    brk_addr_r [BREAK_ENTRIES];
  logic [3:0]               brk_kind_r [BREAK_ENTRIES];
  logic [BCNT_W-1:0]        brk_cnt_r;

  logic [WATCH_ENTRIES-1:0] wch_valid_r;
  logic [ADDR_WIDTH-1:0]    wch_addr_r [WATCH_ENTRIES];
  logic [1:0]               wch_mode_r [WATCH_ENTRIES];
  logic [3:0]               wch_kind_r [WATCH_ENTRIES];
  logic [WCNT_W-1:0]        wch_cnt_r;

  logic [ADDR_WIDTH+31:0] p_ext, f_ext, d_ext;
  logic [ADDR_WIDTH-1:0]  p_addr, f_addr, d_addr;
  logic                   is_break, is_watch;

  logic [BREAK_ENTRIES-1:0] brk_pmatch, brk_fmatch, brk_free, brk_first, brk_slot;
  logic [WATCH_ENTRIES-1:0] wch_pmatch, wch_dmatch, wch_free, wch_first, wch_slot;
  logic [BREAK_ENTRIES-1:0] brk_valid_nxt;
  logic [WATCH_ENTRIES-1:0] wch_valid_nxt;
  logic [BCNT_W-1:0]        brk_cnt_nxt;
  logic [WCNT_W-1:0]        wch_cnt_nxt;
  logic                     brk_wr, wch_wr;
  logic [BCNT_W+4:0]        brk_cnt_ext;
  logic [WCNT_W+4:0]        wch_cnt_ext;

  logic       hw_hit;
  logic [3:0] hw_kind;
  logic       wch_any;
  logic [1:0] wch_mode;
  logic [3:0] wch_kind;
  logic       wch_hit;

  // fit incoming 32-bit addresses to the stored address width
  assign p_ext  = {{ADDR_WIDTH{1'b0}}, req.point_address};
  assign f_ext  = {{ADDR_WIDTH{1'b0}}, req.fetch_address};
  assign d_ext  = {{ADDR_WIDTH{1'b0}}, req.data_address};
  assign p_addr = p_ext[ADDR_WIDTH-1:0];
  assign f_addr = f_ext[ADDR_WIDTH-1:0];
  assign d_addr = d_ext[ADDR_WIDTH-1:0];

  assign is_break = (req.point_type == TYPE_SWBREAK) || (req.point_type == TYPE_HWBREAK);
  assign is_watch = (req.point_type == TYPE_WATCH) || (req.point_type == TYPE_RWATCH) ||
                    (req.point_type == TYPE_AWATCH);

  // associative compare over all entries in parallel
  always_comb begin
    for (int i = 0; i < BREAK_ENTRIES; i++) begin
      brk_pmatch[i] = brk_valid_r[i] && (brk_addr_r[i] == p_addr);
      brk_fmatch[i] = brk_valid_r[i] && (brk_addr_r[i] == f_addr);
    end
    for (int i = 0; i < WATCH_ENTRIES; i++) begin
      wch_pmatch[i] = wch_valid_r[i] && (wch_addr_r[i] == p_addr);
      wch_dmatch[i] = wch_valid_r[i] && (wch_addr_r[i] == d_addr);
    end
  end

  // lowest free slot as a one-hot vector
  assign brk_free  = ~brk_valid_r;
  assign brk_first = brk_free & (~brk_free + BREAK_ENTRIES'(1));
  assign brk_slot  = (|brk_pmatch) ? brk_pmatch : brk_first;
  assign wch_free  = ~wch_valid_r;
  assign wch_first = wch_free & (~wch_free + WATCH_ENTRIES'(1));
  assign wch_slot  = (|wch_pmatch) ? wch_pmatch : wch_first;

  // check path: one-hot select of the matching entry's payload
  always_comb begin
    hw_hit   = 1'b0;
    hw_kind  = '0;
    wch_any  = |wch_dmatch;
    wch_mode = '0;
    wch_kind = '0;
    for (int i = 0; i < BREAK_ENTRIES; i++) begin
      if (brk_fmatch[i] && brk_hw_r[i]) begin
        hw_hit  = 1'b1;
        hw_kind = hw_kind | brk_kind_r[i];
      end
    end
    for (int i = 0; i < WATCH_ENTRIES; i++) begin
      if (wch_dmatch[i]) begin
        wch_mode = wch_mode | wch_mode_r[i];
        wch_kind = wch_kind | wch_kind_r[i];
      end
    end
    wch_hit = wch_any && (((wch_mode == MODE_WATCH) && req.data_write) ||
                          ((wch_mode == MODE_RWATCH) && req.data_read) ||
                          (wch_mode == MODE_AWATCH));
  end

  // table updates and response
  always_comb begin
    brk_valid_nxt = brk_valid_r;
    wch_valid_nxt = wch_valid_r;
    brk_cnt_nxt   = brk_cnt_r;
    wch_cnt_nxt   = wch_cnt_r;
    brk_wr        = 1'b0;
    wch_wr        = 1'b0;
    rsp           = '0;
    brk_cnt_ext   = '0;
    wch_cnt_ext   = '0;
    case (req.command)
      CMD_INSERT: begin
        if (is_break) begin
          brk_wr        = |brk_slot;
          brk_valid_nxt = brk_valid_r | brk_slot;
          if (!(|brk_pmatch) && (|brk_first)) begin
            brk_cnt_nxt = brk_cnt_r + BCNT_W'(1);
          end
          brk_cnt_ext      = {5'd0, brk_cnt_nxt};
          rsp.entry_count  = brk_cnt_ext[4:0];
          rsp.table_full   = ~(|brk_slot);
        end else if (is_watch) begin
          wch_wr        = |wch_slot;
          wch_valid_nxt = wch_valid_r | wch_slot;
          if (!(|wch_pmatch) && (|wch_first)) begin
            wch_cnt_nxt = wch_cnt_r + WCNT_W'(1);
          end
          wch_cnt_ext      = {5'd0, wch_cnt_nxt};
          rsp.entry_count  = wch_cnt_ext[4:0];
          rsp.table_full   = ~(|wch_slot);
        end
      end
      CMD_REMOVE: begin
        if (is_break) begin
          brk_valid_nxt = brk_valid_r & ~brk_pmatch;
          if (|brk_pmatch) begin
            brk_cnt_nxt = brk_cnt_r - BCNT_W'(1);
          end
          brk_cnt_ext     = {5'd0, brk_cnt_nxt};
          rsp.entry_count = brk_cnt_ext[4:0];
        end else if (is_watch) begin
          wch_valid_nxt = wch_valid_r & ~wch_pmatch;
          if (|wch_pmatch) begin
            wch_cnt_nxt = wch_cnt_r - WCNT_W'(1);
          end
          wch_cnt_ext     = {5'd0, wch_cnt_nxt};
          rsp.entry_count = wch_cnt_ext[4:0];
        end
      end
      CMD_CHECK: begin
        if (req.fetch_illegal) begin
          rsp.stop_hit    = 1'b1;
          rsp.stop_signal = SIGILL;
        end else if (hw_hit) begin
          rsp.stop_hit    = 1'b1;
          rsp.stop_signal = SIGTRAP;
          rsp.reason_type = TYPE_HWBREAK;
          rsp.reason_kind = hw_kind;
        end else if (wch_hit) begin
          rsp.stop_hit    = 1'b1;
          rsp.stop_signal = SIGTRAP;
          rsp.reason_type = TYPE_WATCH + {1'b0, wch_mode};
          rsp.reason_kind = wch_kind;
        end
      end
      default: begin
        rsp = '0;
      end
    endcase
  end

  // valid bits and counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brk_valid_r <= '0;
      wch_valid_r <= '0;
      brk_cnt_r   <= '0;
      wch_cnt_r   <= '0;
    end else if (go) begin
      brk_valid_r <= brk_valid_nxt;
      wch_valid_r <= wch_valid_nxt;
      brk_cnt_r   <= brk_cnt_nxt;
      wch_cnt_r   <= wch_cnt_nxt;
    end
  end

  // entry payload, written into the selected slot
  always_ff @(posedge clk) begin
    for (int i = 0; i < BREAK_ENTRIES; i++) begin
      if (go && brk_wr && brk_slot[i]) begin
        brk_addr_r[i] <= p_addr;
        brk_hw_r[i]   <= (req.point_type == TYPE_HWBREAK);
        brk_kind_r[i] <= req.point_kind;
      end
    end
    for (int i = 0; i < WATCH_ENTRIES; i++) begin
      if (go && wch_wr && wch_slot[i]) begin
        wch_addr_r[i] <= p_addr;
        wch_mode_r[i] <= 2'(req.point_type - TYPE_WATCH);
        wch_kind_r[i] <= req.point_kind;
      end
    end
  end

endmodule

// ===== src/breakpoint_watchpoint_matcher_unit.sv =====
// ----------------------------------------------------------------------------
// breakpoint_watchpoint_matcher_unit - debug trigger unit, top level
// Stream wrapper around the breakpoint/watchpoint tables: input request
// register, combinational table access, registered response.
// ----------------------------------------------------------------------------
// Order: request register, table access, response register on out_*.
// Throughput: one request per clock while out_tready allows; every table
//   is a parallel compare of all entries, so no request waits on another.
// Reset (rst_n low, synchronous): both tables empty, counts zero, both
//   pipeline registers empty. Entry payload is not cleared.
// ----------------------------------------------------------------------------
module breakpoint_watchpoint_matcher_unit (
  input  logic         clk,
  input  logic         rst_n,
  // request channel
  input  logic         in_tvalid,
  output logic         in_tready,
  // point_type[2:0], point_address[34:3], point_kind[38:35],
  // fetch_address[70:39], fetch_illegal[71], data_address[103:72],
  // data_read[104], data_write[105], zero pad[111:106]
  input  logic [111:0] in_tdata,
  // command[1:0]
  input  logic [1:0]   in_tuser,
  // response channel
  output logic         out_tvalid,
  input  logic         out_tready,
  // entry_count[4:0], table_full[5], stop_hit[6], stop_signal[8:7],
  // reason_type[11:9], reason_kind[15:12]
  output logic [15:0]  out_tdata
);
  import bwm_pkg::*;

  logic in_valid_r;
  req_t req_r;
  logic out_valid_r;
  rsp_t rsp_r;
  rsp_t rsp;
  logic advance;
  logic go;

  // The response register moves whenever it is empty or being drained;
  // the request register executes against the tables in that same cycle.
  assign advance   = !out_valid_r || out_tready;
  assign go        = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  // capture an accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (go) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      req_r.command       <= cmd_t'(in_tuser);
      req_r.point_type    <= in_tdata[2:0];
      req_r.point_address <= in_tdata[34:3];
      req_r.point_kind    <= in_tdata[38:35];
      req_r.fetch_address <= in_tdata[70:39];
      req_r.fetch_illegal <= in_tdata[71];
      req_r.data_address  <= in_tdata[103:72];
      req_r.data_read     <= in_tdata[104];
      req_r.data_write    <= in_tdata[105];
    end
  end

  // tables and match logic; state changes only on go
  bwm_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .req   (req_r),
    .rsp   (rsp)
  );

  // hold the response until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rsp_r <= rsp;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = rsp_r;

endmodule

// ===== test/breakpoint_watchpoint_matcher_unit_test.sv =====
// ----------------------------------------------------------------------------
// breakpoint_watchpoint_matcher_unit_test - stream-level test of the matcher
// Drives insert, remove and check requests into the unit and predicts every
// response from a private copy of both point tables. Responses are compared
// in order, field by field. The run has a short directed part and then random
// phases that alternately fill and drain the tables. Random stalls fall on
// both sides, and one long receiver hold-off backs up the request side.
// ----------------------------------------------------------------------------
module breakpoint_watchpoint_matcher_unit_test;
  import bwm_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int POOL_SIZE    = 24;
  localparam int PHASES       = 11;
  localparam int PHASE_ITEMS  = 150;
  localparam int HOLD_OFF     = 300;

  // table selectors for the tracker
  localparam int TBL_BREAK = 0;
  localparam int TBL_WATCH = 1;
  localparam int TBL_DEPTH = 64;

  // codes the package does not name
  localparam logic [1:0] CMD_UNKNOWN  = 2'd3;
  localparam logic [2:0] TYPE_BAD_LO  = 3'd5;
  localparam logic [2:0] TYPE_BAD_HI  = 3'd7;

  localparam logic [31:0] ADDR_TOP    = 32'hFFFF_FFFF;
  localparam logic [31:0] ADDR_LOW    = 32'h0000_0000;
  localparam logic [31:0] ADDR_WR     = 32'h0000_1000;
  localparam logic [31:0] ADDR_RD     = 32'h8000_0004;
  localparam logic [31:0] ADDR_ABSENT = 32'h1234_5678;

  // Mirror of both point tables plus the responses still owed by the unit.
  class trigger_tracker;
    logic        used   [2][TBL_DEPTH];
    logic [31:0] where  [2][TBL_DEPTH];
    logic [2:0]  ptype  [2][TBL_DEPTH];
    logic [3:0]  kind   [2][TBL_DEPTH];
    rsp_t        outcomes_due[$];
    int          fail_count;

    function new();
      for (int t = 0; t < 2; t++)
        for (int i = 0; i < TBL_DEPTH; i++) begin
          used[t][i]  = 1'b0;
          where[t][i] = '0;
          ptype[t][i] = '0;
          kind[t][i]  = '0;
        end
      fail_count = 0;
    endfunction

    function int depth_of(int t);
      return (t == TBL_BREAK) ? BREAK_ENTRIES : WATCH_ENTRIES;
    endfunction

    function int lookup(int t, logic [31:0] a);
      for (int i = 0; i < depth_of(t); i++)
        if (used[t][i] && where[t][i] == a) return i;
      return -1;
    endfunction

    function int free_slot(int t);
      for (int i = 0; i < depth_of(t); i++)
        if (!used[t][i]) return i;
      return -1;
    endfunction

    function logic [4:0] occupancy(int t);
      int c;
      c = 0;
      for (int i = 0; i < depth_of(t); i++)
        if (used[t][i]) c++;
      return 5'(c);
    endfunction

    // Apply one request to the mirror and return the response it should get.
    function rsp_t predict_outcome(req_t r);
      rsp_t       o;
      int         t;
      int         slot;
      logic       known;
      logic [2:0] m;
      o     = '0;
      known = r.point_type <= TYPE_AWATCH;
      t     = (r.point_type <= TYPE_HWBREAK) ? TBL_BREAK : TBL_WATCH;
      case (r.command)
        CMD_INSERT: begin
          if (known) begin
            slot = lookup(t, r.point_address);
            if (slot < 0) slot = free_slot(t);
            if (slot < 0) begin
              o.table_full = 1'b1;
            end else begin
              used[t][slot]  = 1'b1;
              where[t][slot] = r.point_address;
              ptype[t][slot] = r.point_type;
              kind[t][slot]  = r.point_kind;
            end
            o.entry_count = occupancy(t);
          end
        end
        CMD_REMOVE: begin
          // any type of the right table removes the entry
          if (known) begin
            slot = lookup(t, r.point_address);
            if (slot >= 0) used[t][slot] = 1'b0;
            o.entry_count = occupancy(t);
          end
        end
        CMD_CHECK: begin
          if (r.fetch_illegal) begin
            o.stop_hit    = 1'b1;
            o.stop_signal = SIGILL;
          end else begin
            slot = lookup(TBL_BREAK, r.fetch_address);
            if (slot >= 0 && ptype[TBL_BREAK][slot] == TYPE_HWBREAK) begin
              o.stop_hit    = 1'b1;
              o.stop_signal = SIGTRAP;
              o.reason_type = TYPE_HWBREAK;
              o.reason_kind = kind[TBL_BREAK][slot];
            end else begin
              // software breaks never fire; fall through to the watch table
              slot = lookup(TBL_WATCH, r.data_address);
              if (slot >= 0) begin
                m = ptype[TBL_WATCH][slot];
                if ((m == TYPE_WATCH && r.data_write) || (m == TYPE_RWATCH && r.data_read) ||
                    m == TYPE_AWATCH) begin
                  o.stop_hit    = 1'b1;
                  o.stop_signal = SIGTRAP;
                  o.reason_type = m;
                  o.reason_kind = kind[TBL_WATCH][slot];
                end
              end
            end
          end
        end
        default: ;
      endcase
      return o;
    endfunction

    function void note_request(req_t r);
      outcomes_due.push_back(predict_outcome(r));
    endfunction

    function void compare_field(string field, int want, int got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, actual %0d", field, want, got);
        fail_count++;
      end
    endfunction

    function void check_outcome(logic [15:0] raw);
      rsp_t got;
      rsp_t want;
      got = rsp_t'(raw);
      if (outcomes_due.size() == 0) begin
        $error("unexpected response 0x%04h with nothing outstanding", raw);
        fail_count++;
        return;
      end
      want = outcomes_due.pop_front();
      compare_field("entry_count", want.entry_count, got.entry_count);
      compare_field("table_full",  want.table_full,  got.table_full);
      compare_field("stop_hit",    want.stop_hit,    got.stop_hit);
      compare_field("stop_signal", want.stop_signal, got.stop_signal);
      compare_field("reason_type", want.reason_type, got.reason_type);
      compare_field("reason_kind", want.reason_kind, got.reason_kind);
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [111:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [15:0]  out_tdata;

  trigger_tracker tracker;
  logic [31:0]    addr_pool[POOL_SIZE];
  bit             idle_on;
  int             hold_cycles;
  int             cycle_count = 0;

  breakpoint_watchpoint_matcher_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // count cycles and give up well past the slowest legal run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic req_t make_request(cmd_t c, logic [2:0] t, logic [31:0] pa,
                                        logic [3:0] k, logic [31:0] fa, logic fi,
                                        logic [31:0] da, logic rd, logic wr);
    req_t r;
    r.command       = c;
    r.point_type    = t;
    r.point_address = pa;
    r.point_kind    = k;
    r.fetch_address = fa;
    r.fetch_illegal = fi;
    r.data_address  = da;
    r.data_read     = rd;
    r.data_write    = wr;
    return r;
  endfunction

  // mostly reuse a small address set so lookups hit and the tables fill
  function automatic logic [31:0] pick_address();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  // Random request; a filling phase leans on inserts, a draining one on removes.
  function automatic req_t random_request(bit filling);
    req_t r;
    int   roll;
    r.command       = CMD_CHECK;
    r.point_type    = 3'($urandom_range(0, 4));
    r.point_address = pick_address();
    r.point_kind    = 4'($urandom);
    r.fetch_address = pick_address();
    r.fetch_illegal = ($urandom_range(0, 9) == 0);
    r.data_address  = pick_address();
    r.data_read     = 1'($urandom_range(0, 1));
    r.data_write    = 1'($urandom_range(0, 1));
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      r.command = cmd_t'(CMD_UNKNOWN);
    end else if (roll < 8) begin
      r.command    = $urandom_range(0, 1) ? CMD_INSERT : CMD_REMOVE;
      r.point_type = 3'($urandom_range(TYPE_BAD_LO, TYPE_BAD_HI));
    end else if (roll < (filling ? 58 : 23)) begin
      r.command = CMD_INSERT;
    end else if (roll < 68) begin
      r.command = CMD_REMOVE;
    end
    return r;
  endfunction

  // Offer one request, hold it until accepted, then idle for a random gap.
  task automatic issue_request(req_t r);
    int gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= r.command;
    in_tdata  <= {6'b0, r.data_write, r.data_read, r.data_address, r.fetch_illegal,
                  r.fetch_address, r.point_kind, r.point_address, r.point_type};
    do @(posedge clk); while (!in_tready);
    tracker.note_request(r);
    if (gap > 0) begin
      // drop valid so the accepted request is not taken twice
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic lower_valid();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_all_responses();
    while (tracker.outcomes_due.size() != 0) @(posedge clk);
  endtask

  // Receiver: stall a random number of cycles before each response, or
  // for a long stretch when a hold-off is requested.
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_cycles > 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = idle_on ? $urandom_range(0, 6) : 0;
      end
      if (stall > 0) begin
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
        @(negedge clk);
        out_tready <= 1'b1;
      end else if (!out_tready) begin
        @(negedge clk);
        out_tready <= 1'b1;
      end
      do @(posedge clk); while (!out_tvalid);
      tracker.check_outcome(out_tdata);
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    idle_on     = 1'b1;
    hold_cycles = 0;
    tracker     = new();

    // seed the address set with the extremes and a few random values
    addr_pool[0] = ADDR_LOW;
    addr_pool[1] = ADDR_TOP;
    addr_pool[2] = 32'h8000_0000;
    addr_pool[3] = 32'h0000_0001;
    for (int i = 4; i < POOL_SIZE; i++) addr_pool[i] = $urandom;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // fill both tables with every point type, extremes of address and kind
    issue_request(make_request(CMD_INSERT, TYPE_HWBREAK, ADDR_TOP, 4'hF, 0, 0, 0, 0, 0));
    issue_request(make_request(CMD_INSERT, TYPE_SWBREAK, ADDR_LOW, 4'h0, 0, 0, 0, 0, 0));
    issue_request(make_request(CMD_INSERT, TYPE_WATCH,   ADDR_WR,  4'h1, 0, 0, 0, 0, 0));
    issue_request(make_request(CMD_INSERT, TYPE_RWATCH,  ADDR_RD,  4'h2, 0, 0, 0, 0, 0));
    issue_request(make_request(CMD_INSERT, TYPE_AWATCH,  ADDR_TOP, 4'hF, 0, 0, 0, 0, 0));
    // illegal fetch beats a matching hardware break
    issue_request(make_request(CMD_CHECK, 0, 0, 0, ADDR_TOP, 1, ADDR_TOP, 1, 1));
    issue_request(make_request(CMD_CHECK, 0, 0, 0, ADDR_TOP, 0, ADDR_LOW, 0, 0));
    // software break is stored but silent; write watch needs a write
    issue_request(make_request(CMD_CHECK, 0, 0, 0, ADDR_LOW, 0, ADDR_WR, 1, 0));
    issue_request(make_request(CMD_CHECK, 0, 0, 0, ADDR_LOW, 0, ADDR_WR, 0, 1));
    issue_request(make_request(CMD_CHECK, 0, 0, 0, ADDR_ABSENT, 0, ADDR_RD, 1, 0));
    issue_request(make_request(CMD_CHECK, 0, 0, 0, ADDR_ABSENT, 0, ADDR_RD, 0, 1));
    issue_request(make_request(CMD_CHECK, 0, 0, 0, ADDR_ABSENT, 0, ADDR_TOP, 0, 0));
    // overwrite turns the software break into a hardware one
    issue_request(make_request(CMD_INSERT, TYPE_HWBREAK, ADDR_LOW, 4'h7, 0, 0, 0, 0, 0));
    issue_request(make_request(CMD_CHECK, 0, 0, 0, ADDR_LOW, 0, ADDR_RD, 1, 0));
    // overwrite changes the watch mode
    issue_request(make_request(CMD_INSERT, TYPE_AWATCH, ADDR_WR, 4'h9, 0, 0, 0, 0, 0));
    issue_request(make_request(CMD_CHECK, 0, 0, 0, ADDR_ABSENT, 0, ADDR_WR, 0, 0));
    // remove ignores the stored type; absent address leaves the count
    issue_request(make_request(CMD_REMOVE, TYPE_RWATCH,  ADDR_WR,     0, 0, 0, 0, 0, 0));
    issue_request(make_request(CMD_REMOVE, TYPE_SWBREAK, ADDR_TOP,    0, 0, 0, 0, 0, 0));
    issue_request(make_request(CMD_REMOVE, TYPE_HWBREAK, ADDR_ABSENT, 0, 0, 0, 0, 0, 0));
    // unknown types and the unused command code are ignored
    issue_request(make_request(CMD_INSERT, TYPE_BAD_LO, ADDR_ABSENT, 4'h3, 0, 0, 0, 0, 0));
    issue_request(make_request(CMD_REMOVE, TYPE_BAD_HI, ADDR_TOP,    4'h3, 0, 0, 0, 0, 0));
    issue_request(make_request(cmd_t'(CMD_UNKNOWN), TYPE_HWBREAK, ADDR_LOW, 4'hF,
                               ADDR_LOW, 0, ADDR_TOP, 1, 1));

    // random phases: even ones fill the tables, odd ones drain them;
    // every fourth phase runs without idling
    for (int p = 0; p < PHASES; p++) begin
      idle_on = (p % 4 != 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 1 && i == 40) hold_cycles = HOLD_OFF;
        if (p == 4 && i == 0) begin
          // hold the sender until every outstanding response is back
          lower_valid();
          wait_all_responses();
        end
        issue_request(random_request(p % 2 == 0));
      end
    end

    lower_valid();
    wait_all_responses();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/bwm_pkg.sv
src/bwm_core.sv
src/breakpoint_watchpoint_matcher_unit.sv
test/breakpoint_watchpoint_matcher_unit_test.sv
